// File: rtl/rhcm_pkg.sv
// Shared constants, types and the control store of the Mersenne hash concatenation block.
package rhcm_pkg;

    // Modulus p = 2^MODULUS_EXPONENT - 1 and the number of exponent bits walked.
    localparam int MODULUS_EXPONENT = 61;
    localparam int LENGTH_BITS      = 48;

    // Fixed widths of the stream fields.
    localparam int HASH_W      = 61;
    localparam int LEN_FIELD_W = 48;
    localparam int S_FIELDS_W  = 2 * HASH_W + LEN_FIELD_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((HASH_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;
    localparam logic REG_HASH_BASE = 1'b0;
    localparam logic [HASH_W-1:0] HASH_BASE_RESET = HASH_W'(256);

    // Multiplier operand split into a low and a high half.
    localparam int OPW    = HASH_W;
    localparam int HALF_W = 32;
    localparam int HI_W   = OPW - HALF_W;
    localparam int P00_W  = 2 * HALF_W;
    localparam int P01_W  = HALF_W + HI_W;
    localparam int P11_W  = 2 * HI_W;
    localparam int PROD_W = 2 * OPW;

    localparam logic [MODULUS_EXPONENT-1:0] PRIME = '1;

    localparam int CNT_W = $clog2(LENGTH_BITS + 1);

    // Control store layout.
    localparam int UC_DEPTH = 14;
    localparam int STEP_W   = $clog2(UC_DEPTH);

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE       = STEP_W'(0);
    localparam step_t STEP_NORM_LEFT  = STEP_W'(1);
    localparam step_t STEP_NORM_RIGHT = STEP_W'(2);
    localparam step_t STEP_NORM_BASE  = STEP_W'(3);
    localparam step_t STEP_NORM_WAIT  = STEP_W'(4);
    localparam step_t STEP_BIT_MUL    = STEP_W'(5);
    localparam step_t STEP_BIT_SQUARE = STEP_W'(6);
    localparam step_t STEP_BIT_WAIT   = STEP_W'(7);
    localparam step_t STEP_BIT_LOOP   = STEP_W'(8);
    localparam step_t STEP_LEFT_MUL   = STEP_W'(9);
    localparam step_t STEP_LEFT_WAIT  = STEP_W'(10);
    localparam step_t STEP_JOIN       = STEP_W'(11);
    localparam step_t STEP_OUTPUT     = STEP_W'(12);
    localparam step_t STEP_RETURN     = STEP_W'(13);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_NEXT_BIT,
        ACT_JOIN,
        ACT_OUTPUT
    } action_t;

    typedef enum logic [1:0] {
        ISSUE_NONE,
        ISSUE_ALWAYS,
        ISSUE_IF_BIT
    } issue_t;

    typedef enum logic [2:0] {
        SRC_ACC,
        SRC_SQ,
        SRC_LEFT,
        SRC_RIGHT,
        SRC_ONE
    } src_t;

    typedef enum logic [1:0] {
        DST_ACC,
        DST_SQ,
        DST_LEFT,
        DST_RIGHT
    } dst_t;

    typedef enum logic [2:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_IF_NO_INPUT,
        JMP_IF_BUSY,
        JMP_IF_MORE_BITS,
        JMP_IF_OUT_FULL
    } cond_t;

    typedef struct packed {
        action_t action;
        issue_t  issue;
        src_t    a_sel;
        src_t    b_sel;
        dst_t    dest;
        cond_t   cond;
        step_t   target;
    } ucode_t;

    function automatic ucode_t make_uc(input action_t act, input issue_t iss, input src_t a,
                                       input src_t b, input dst_t d, input cond_t c,
                                       input step_t tgt);
        ucode_t w;
        w.action = act;
        w.issue  = iss;
        w.a_sel  = a;
        w.b_sel  = b;
        w.dest   = d;
        w.cond   = c;
        w.target = tgt;
        return w;
    endfunction

    // The program: take a beat, normalise the operands, walk the exponent bits, then join and output.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = make_uc(ACT_NONE, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC, JMP_NEVER, STEP_IDLE);
        unique case (step)
            STEP_IDLE:       w = make_uc(ACT_ACCEPT, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_IF_NO_INPUT, STEP_IDLE);
            STEP_NORM_LEFT:  w = make_uc(ACT_NONE, ISSUE_ALWAYS, SRC_LEFT, SRC_ONE, DST_LEFT,
                                         JMP_NEVER, STEP_IDLE);
            STEP_NORM_RIGHT: w = make_uc(ACT_NONE, ISSUE_ALWAYS, SRC_RIGHT, SRC_ONE, DST_RIGHT,
                                         JMP_NEVER, STEP_IDLE);
            STEP_NORM_BASE:  w = make_uc(ACT_NONE, ISSUE_ALWAYS, SRC_SQ, SRC_ONE, DST_SQ,
                                         JMP_NEVER, STEP_IDLE);
            STEP_NORM_WAIT:  w = make_uc(ACT_NONE, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_IF_BUSY, STEP_NORM_WAIT);
            STEP_BIT_MUL:    w = make_uc(ACT_NONE, ISSUE_IF_BIT, SRC_ACC, SRC_SQ, DST_ACC,
                                         JMP_NEVER, STEP_IDLE);
            STEP_BIT_SQUARE: w = make_uc(ACT_NEXT_BIT, ISSUE_ALWAYS, SRC_SQ, SRC_SQ, DST_SQ,
                                         JMP_NEVER, STEP_IDLE);
            STEP_BIT_WAIT:   w = make_uc(ACT_NONE, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_IF_BUSY, STEP_BIT_WAIT);
            STEP_BIT_LOOP:   w = make_uc(ACT_NONE, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_IF_MORE_BITS, STEP_BIT_MUL);
            STEP_LEFT_MUL:   w = make_uc(ACT_NONE, ISSUE_ALWAYS, SRC_ACC, SRC_LEFT, DST_ACC,
                                         JMP_NEVER, STEP_IDLE);
            STEP_LEFT_WAIT:  w = make_uc(ACT_NONE, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_IF_BUSY, STEP_LEFT_WAIT);
            STEP_JOIN:       w = make_uc(ACT_JOIN, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_NEVER, STEP_IDLE);
            STEP_OUTPUT:     w = make_uc(ACT_OUTPUT, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_IF_OUT_FULL, STEP_OUTPUT);
            STEP_RETURN:     w = make_uc(ACT_NONE, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_ALWAYS, STEP_IDLE);
            default:         w = make_uc(ACT_NONE, ISSUE_NONE, SRC_ACC, SRC_ONE, DST_ACC,
                                         JMP_ALWAYS, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/rolling_hash_concat_mersenne.sv
// Top level: microcoded Karp-Rabin fingerprint concatenation modulo a Mersenne prime.
//
// Each input beat on the s_ channel carries the left fingerprint, the right fingerprint
// and right_length. The block returns one beat on the m_ channel holding joined_hash, which is
// (hash_base^right_length * left_fp + right_fp) mod p, p = 2^61 - 1, canonical.
// hash_base is written through the APB-style port at byte address 0 (64-bit data);
// it must only be written while no beat is in progress.
// A small program in a read-only control store drives one shared modular multiplier
// (four-stage pipeline of 32-bit partial products, sum, and two Mersenne folds).
// The exponent is walked one bit at a time, least significant first: multiply, square,
// wait on the pipeline, loop test. The time per beat is bound by the chain of squarings
// through the multiplier pipeline. One beat is worked on at a time.
// The result sits in an output register; once it is loaded the sequencer returns to
// its idle step and takes the next input beat even while the receiver stalls. A new
// result waits in the output step until the receiver has taken the previous one.
// Reset (aresetn low at a clock edge) empties the multiplier pipeline and the output
// register, sets hash_base to 256 and returns the sequencer to its idle step.
module rolling_hash_concat_mersenne (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: left_fp [60:0], right_fp [121:61], right_length [169:122], zero pad
    input  logic [rhcm_pkg::S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: joined_hash [60:0], zero pad
    output logic [rhcm_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rhcm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rhcm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rhcm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rhcm_pkg::*;

    localparam int K = MODULUS_EXPONENT;

    // Sequencer state.
    step_t             step_reg, step_next;
    ucode_t            uc;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Datapath registers. All operands are held at the full field width so that raw
    // inputs can be normalised by multiplying them by one.
    logic [HASH_W-1:0]      base_reg;
    logic [OPW-1:0]         acc_reg, acc_next;
    logic [OPW-1:0]         sq_reg, sq_next;
    logic [OPW-1:0]         left_reg, left_next;
    logic [OPW-1:0]         right_reg, right_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [HASH_W-1:0] out_reg, out_next;

    // Multiplier pipeline.
    logic [OPW-1:0]   mul_a, mul_b;
    logic             mul_issue;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    dst_t             d1_reg, d2_reg, d3_reg, d4_reg;
    logic [P00_W-1:0] p00_reg;
    logic [P01_W-1:0] p01_reg, p10_reg;
    logic [P11_W-1:0] p11_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [K:0]       fold_reg;
    logic [OPW-1:0]   res_reg;
    logic [K-1:0]     fold2;

    logic             s_accept;
    logic             out_free;
    logic             mul_busy;
    logic             jump;
    logic [K:0]       join_sum;
    logic [K:0]       join_mod;
    logic             cfg_write;

    // ------------------------------------------------------------------
    // Configuration port: one 61-bit register at byte address 0.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[3] == REG_HASH_BASE);

    always_comb begin
        if (paddr[3] == REG_HASH_BASE) begin
            prdata = APB_DATA_W'(base_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= HASH_BASE_RESET;
        end else if (cfg_write) begin
            base_reg <= pwdata[HASH_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: fetch the control word for the current step and branch.
    // ------------------------------------------------------------------
    assign uc       = ucode_rom(step_reg);
    assign s_tready = (uc.action == ACT_ACCEPT);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    // The last stage writes back at the same edge that the sequencer leaves a wait
    // step, so the following step already sees the new value.
    assign mul_busy = v1_reg || v2_reg || v3_reg;

    always_comb begin
        unique case (uc.cond)
            JMP_NEVER:        jump = 1'b0;
            JMP_ALWAYS:       jump = 1'b1;
            JMP_IF_NO_INPUT:  jump = !s_tvalid;
            JMP_IF_BUSY:      jump = mul_busy;
            JMP_IF_MORE_BITS: jump = (cnt_reg != CNT_W'(LENGTH_BITS));
            JMP_IF_OUT_FULL:  jump = !out_free;
            default:          jump = 1'b0;
        endcase
        step_next = jump ? uc.target : step_t'(step_reg + 1'b1);
    end

    // ------------------------------------------------------------------
    // Operand selection and issue into the multiplier.
    // ------------------------------------------------------------------
    function automatic logic [OPW-1:0] pick(input src_t s, input logic [OPW-1:0] acc,
                                            input logic [OPW-1:0] sq,
                                            input logic [OPW-1:0] lft,
                                            input logic [OPW-1:0] rgt);
        logic [OPW-1:0] v;
        unique case (s)
            SRC_ACC:   v = acc;
            SRC_SQ:    v = sq;
            SRC_LEFT:  v = lft;
            SRC_RIGHT: v = rgt;
            SRC_ONE:   v = OPW'(1);
            default:   v = OPW'(1);
        endcase
        return v;
    endfunction

    always_comb begin
        mul_a = pick(uc.a_sel, acc_reg, sq_reg, left_reg, right_reg);
        mul_b = pick(uc.b_sel, acc_reg, sq_reg, left_reg, right_reg);
        unique case (uc.issue)
            ISSUE_NONE:   mul_issue = 1'b0;
            ISSUE_ALWAYS: mul_issue = 1'b1;
            ISSUE_IF_BIT: mul_issue = len_reg[0];
            default:      mul_issue = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Modular multiplier: partial products, full product, first fold, second fold.
    // Operands are below 2^61 and the product below 2^(2K), so two folds and a
    // final test against p give the canonical residue.
    // ------------------------------------------------------------------
    assign fold2 = fold_reg[K-1:0] + K'(fold_reg[K]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= mul_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d1_reg   <= uc.dest;
        d2_reg   <= d1_reg;
        d3_reg   <= d2_reg;
        d4_reg   <= d3_reg;
        p00_reg  <= P00_W'(mul_a[HALF_W-1:0]) * P00_W'(mul_b[HALF_W-1:0]);
        p01_reg  <= P01_W'(mul_a[HALF_W-1:0]) * P01_W'(mul_b[OPW-1:HALF_W]);
        p10_reg  <= P01_W'(mul_a[OPW-1:HALF_W]) * P01_W'(mul_b[HALF_W-1:0]);
        p11_reg  <= P11_W'(mul_a[OPW-1:HALF_W]) * P11_W'(mul_b[OPW-1:HALF_W]);
        prod_reg <= PROD_W'(p00_reg)
                  + (PROD_W'(p01_reg) << HALF_W)
                  + (PROD_W'(p10_reg) << HALF_W)
                  + (PROD_W'(p11_reg) << (2 * HALF_W));
        fold_reg <= (K + 1)'(prod_reg[K-1:0]) + (K + 1)'(prod_reg[2*K-1:K]);
        res_reg  <= (fold2 == PRIME) ? '0 : OPW'(fold2);
    end

    // ------------------------------------------------------------------
    // Register updates driven by the control word and the write-back stage.
    // ------------------------------------------------------------------
    always_comb begin
        join_sum = (K + 1)'(acc_reg[K-1:0]) + (K + 1)'(right_reg[K-1:0]);
        join_mod = (join_sum >= (K + 1)'(PRIME)) ? join_sum - (K + 1)'(PRIME) : join_sum;
    end

    always_comb begin
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (v4_reg) begin
            unique case (d4_reg)
                DST_ACC:   acc_next   = res_reg;
                DST_SQ:    sq_next    = res_reg;
                DST_LEFT:  left_next  = res_reg;
                DST_RIGHT: right_next = res_reg;
                default:   acc_next   = res_reg;
            endcase
        end

        unique case (uc.action)
            ACT_ACCEPT: begin
                if (s_accept) begin
                    left_next  = s_tdata[HASH_W-1:0];
                    right_next = s_tdata[2*HASH_W-1:HASH_W];
                    len_next   = LENGTH_BITS'(s_tdata[2*HASH_W+LEN_FIELD_W-1:2*HASH_W]);
                    sq_next    = base_reg;
                    acc_next   = OPW'(1);
                    cnt_next   = '0;
                end
            end
            ACT_NEXT_BIT: begin
                len_next = len_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
            end
            ACT_JOIN: begin
                acc_next = OPW'(join_mod[K-1:0]);
            end
            ACT_OUTPUT: begin
                if (out_free) begin
                    out_next     = HASH_W'(acc_reg);
                    m_valid_next = 1'b1;
                end
            end
            ACT_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        len_reg   <= len_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

// File: dv/rolling_hash_concat_mersenne_tb.sv
// Self-checking testbench for the Mersenne-prime Karp-Rabin hash concatenation block.
module rolling_hash_concat_mersenne_tb;

    import rhcm_pkg::*;

    // Field widths and the modulus p = 2^61 - 1 as the predictor sees it.
    localparam int HW = HASH_W;
    localparam int LW = LEN_FIELD_W;

    typedef logic [HW-1:0] hash_t;
    typedef logic [LW-1:0] len_t;

    localparam hash_t MERSENNE_P   = '1;
    localparam hash_t MERSENNE_PM1 = MERSENNE_P - 1;
    localparam hash_t MERSENNE_PM2 = MERSENNE_P - 2;
    localparam len_t  LEN_MAX      = '1;

    // hash_base is register 0; registers are 64 bits wide, so 8 bytes apart.
    localparam logic [APB_ADDR_W-1:0] ADDR_HASH_BASE = APB_ADDR_W'(8 * REG_HASH_BASE);
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE     = APB_ADDR_W'(8);

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 400;
    localparam int SEGMENTS        = 6;
    localparam int SEGMENT_BEATS   = 108;

    // Clock and the single reset at the start of the run.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // Every input of the block starts at a known value.
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rolling_hash_concat_mersenne dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Our own copy of hash_base, and the fingerprints still owed by the block, oldest first.
    hash_t base_copy = hash_t'(256);
    hash_t joined_fifo [$];

    int mismatch_count = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int base_writes    = 0;
    int stall_cycles   = 0;

    // Idle percentages for each side and the request for a long receiver hold-off.
    int send_idle_pct = 9;
    int recv_idle_pct = 45;
    bit hold_off_pending = 1'b0;

    // ------------------------------------------------------------------
    // Predictor: arithmetic modulo p written with wide vectors.
    // ------------------------------------------------------------------

    // Canonical residue of any 64-bit value: fold the bits above bit 60 back in twice.
    function automatic hash_t mersenne_canon(input logic [63:0] v);
        logic [63:0] f;
        f = {3'b000, v[HW-1:0]} + (v >> HW);
        f = {3'b000, f[HW-1:0]} + (f >> HW);
        if (f[HW-1:0] == MERSENNE_P)
            f = '0;
        return f[HW-1:0];
    endfunction

    // Product of two canonical residues, split at bit 61 of the full product.
    function automatic hash_t mersenne_mul(input hash_t a, input hash_t b);
        logic [2*HW-1:0] prod;
        logic [63:0]     sum;
        prod = (2*HW)'(a) * (2*HW)'(b);
        sum  = 64'(prod[HW-1:0]) + 64'(prod[2*HW-1:HW]);
        return mersenne_canon(sum);
    endfunction

    // base^exponent by square-and-multiply, least significant exponent bit first.
    function automatic hash_t base_power(input hash_t b, input len_t e);
        hash_t acc;
        hash_t sq;
        acc = hash_t'(1);
        sq  = mersenne_canon(64'(b));
        for (int i = 0; i < LW; i++) begin
            if (e[i])
                acc = mersenne_mul(acc, sq);
            sq = mersenne_mul(sq, sq);
        end
        return acc;
    endfunction

    function automatic hash_t predict_joined(input hash_t left, input hash_t right,
                                             input len_t len);
        hash_t lc;
        hash_t rc;
        hash_t scaled;
        lc     = mersenne_canon(64'(left));
        rc     = mersenne_canon(64'(right));
        scaled = mersenne_mul(base_power(base_copy, len), lc);
        return mersenne_canon(64'(scaled) + 64'(rc));
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Where the fingerprint is obvious it is typed in;
    // the other rows fall back on the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        set_base;
        logic [63:0] base_wdata;
        hash_t       left;
        hash_t       right;
        len_t        len;
        logic        typed;
        hash_t       joined;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // Reset base of 256.
        '{1'b0, 64'd0, 0, 0, 0, 1'b1, 0},
        '{1'b0, 64'd0, 5, 7, 0, 1'b1, 12},
        '{1'b0, 64'd0, 1, 0, 1, 1'b1, 256},
        '{1'b0, 64'd0, 1, 0, 2, 1'b1, 65536},
        '{1'b0, 64'd0, 2, 0, 7, 1'b1, 61'h0200_0000_0000_0000},
        // 256^8 = 2^64, which is 8 times 2^61 and so folds to 8.
        '{1'b0, 64'd0, 1, 0, 8, 1'b1, 8},
        // Hashes equal to p act as zero.
        '{1'b0, 64'd0, MERSENNE_P, 3, 0, 1'b1, 3},
        '{1'b0, 64'd0, MERSENNE_PM1, 1, 0, 1'b1, 0},
        '{1'b0, 64'd0, MERSENNE_PM1, MERSENNE_PM1, 0, 1'b1, MERSENNE_PM2},
        '{1'b0, 64'd0, MERSENNE_P, MERSENNE_P, 5, 1'b1, 0},
        '{1'b0, 64'd0, 1, 0, LEN_MAX, 1'b0, 0},
        '{1'b0, 64'd0, MERSENNE_PM1, MERSENNE_PM1, LEN_MAX, 1'b0, 0},
        // A zero base still gives a power of one at zero length.
        '{1'b1, 64'd0, 9, 4, 0, 1'b1, 13},
        '{1'b0, 64'd0, 9, 4, 3, 1'b1, 4},
        // A base equal to p behaves as a zero base.
        '{1'b1, {3'b000, MERSENNE_P}, 9, 4, 0, 1'b1, 13},
        '{1'b0, 64'd0, 9, 4, 1, 1'b1, 4},
        // Base p-1 is minus one; the top bits of the write data are dropped.
        '{1'b1, {3'b111, MERSENNE_PM1}, 1, 0, 1, 1'b1, MERSENNE_PM1},
        '{1'b0, 64'd0, 1, 0, 2, 1'b1, 1},
        '{1'b0, 64'd0, 1, 0, LEN_MAX, 1'b1, MERSENNE_PM1},
        // Base 2: 2^61 folds to one.
        '{1'b1, 64'd2, 1, 0, 61, 1'b1, 1},
        '{1'b0, 64'd0, 1, 0, 60, 1'b1, 61'h1000_0000_0000_0000},
        '{1'b0, 64'd0, 3, MERSENNE_PM1, 62, 1'b0, 0},
        '{1'b1, 64'h0123_4567_89AB_CDEF, MERSENNE_PM1, 12345, LEN_MAX, 1'b0, 0},
        '{1'b0, 64'd0, 61'h0AAA_AAAA_AAAA_AAAA, 61'h1555_5555_5555_5555,
          48'h5555_5555_5555, 1'b0, 0}
    };

    // ------------------------------------------------------------------
    // Random field values, biased towards the edges of each range.
    // ------------------------------------------------------------------
    function automatic hash_t pick_hash();
        logic [63:0] raw;
        hash_t       h;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       h = '0;
            1:       h = MERSENNE_P;
            2:       h = MERSENNE_PM1;
            3:       h = hash_t'($urandom_range(255));
            default: h = raw[HW-1:0];
        endcase
        return h;
    endfunction

    function automatic len_t pick_length();
        logic [63:0] raw;
        len_t        n;
        raw = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       n = '0;
            1:       n = LEN_MAX;
            2:       n = len_t'($urandom_range(64, 1));
            3:       n = len_t'(1) << $urandom_range(LW - 1);
            default: n = raw[LW-1:0];
        endcase
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge; handshakes are judged on the rising edge.
    // ------------------------------------------------------------------

    // Offer one beat, idling at random first, and record the fingerprint it is owed.
    task automatic send_beat(input hash_t left, input hash_t right, input len_t len,
                             input logic typed, input hash_t typed_joined);
        bit accepted;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge aclk);
            if ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'({len, right, left});
                @(posedge aclk);
                while (!s_tready)
                    @(posedge aclk);
                accepted = 1'b1;
            end
        end
        // The base cannot change while the beat is in flight, so predict at once.
        joined_fifo.push_back(typed ? typed_joined : predict_joined(left, right, len));
        beats_sent++;
    endtask

    // Stop offering and wait until every owed fingerprint has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (joined_fifo.size() != 0)
            @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the accepting edge.
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [63:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (addr == ADDR_HASH_BASE)
            base_copy = data[HW-1:0];
        base_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read hash_base back and compare it with our copy.
    task automatic check_base_readback();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_HASH_BASE;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== APB_DATA_W'(base_copy)) begin
            $error("prdata: expected %h, actual %h", APB_DATA_W'(base_copy), prdata);
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Configuration only ever happens with the block idle.
    task automatic set_base(input logic [63:0] data);
        drain_results();
        write_reg(ADDR_HASH_BASE, data);
        check_base_readback();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off counted here
    // so that the block fills up and has to stall its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result beat against the oldest owed fingerprint.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        hash_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (joined_fifo.size() == 0) begin
                $error("joined_hash: result beat %h with nothing expected", m_tdata);
                mismatch_count++;
            end else begin
                want = joined_fifo.pop_front();
                if (m_tdata[HW-1:0] !== want) begin
                    $error("joined_hash: expected %h, actual %h", want, m_tdata[HW-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[M_TDATA_W-1:HW] !== '0) begin
                    $error("m_tdata pad: expected %h, actual %h",
                           {(M_TDATA_W - HW){1'b0}}, m_tdata[M_TDATA_W-1:HW]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with no beat moving on either stream means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] seg_base;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The register must read back its reset value before anything is written.
        check_base_readback();

        // Directed beats under the first idling pattern.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].set_base)
                set_base(dir_rows[r].base_wdata);
            send_beat(dir_rows[r].left, dir_rows[r].right, dir_rows[r].len,
                      dir_rows[r].typed, dir_rows[r].joined);
        end

        // Random beats in segments, each under its own hash_base. Segments 0-1 have a
        // busy sender and lazy receiver, 2-3 the other way round, 4-5 no idling at all.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                1:       seg_base = '1;
                3:       seg_base = 64'($urandom_range(1000, 2));
                default: seg_base = {$urandom, $urandom};
            endcase
            drain_results();
            if (seg == 4) begin
                // A write to an unused register must leave hash_base alone.
                write_reg(ADDR_SPARE, {$urandom, $urandom});
                check_base_readback();
            end
            set_base(seg_base);
            send_idle_pct = (seg < 2) ? 9 : (seg < 4) ? 45 : 0;
            recv_idle_pct = (seg < 2) ? 45 : (seg < 4) ? 9 : 0;

            for (int n = 0; n < SEGMENT_BEATS; n++) begin
                if (seg == 2 && n == 50)
                    drain_results();
                if (seg == 4 && n == 20)
                    hold_off_pending = 1'b1;
                send_beat(pick_hash(), pick_hash(), pick_length(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input beats and %0d result beats across %0d register writes,",
                 beats_sent, results_seen, base_writes);
        $display("including edge hashes and lengths, a long receiver hold-off and a sender pause.");
        if (mismatch_count == 0 && joined_fifo.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/rhcm_pkg.sv
rtl/rolling_hash_concat_mersenne.sv
dv/rolling_hash_concat_mersenne_tb.sv
